@@ src/fdct_pkg.sv @@
// Shared types, constants and helpers for the 8x8 forward DCT.
`timescale 1ns / 1ps
package fdct_pkg;

  localparam int SAMPLE_BITS_DEF = 13;
  localparam int PASS_BITS = 18;
  localparam int COEF_BITS = 19;
  localparam int CONST_BITS = 15;
  localparam int ROUND_SHIFT = 14;
  localparam int ROUND_BIAS = 8192;

  localparam logic [CONST_BITS-1:0] C4 = 15'd16069;
  localparam logic [CONST_BITS-1:0] C8 = 15'd15137;
  localparam logic [CONST_BITS-1:0] C12 = 15'd13623;
  localparam logic [CONST_BITS-1:0] C16 = 15'd11585;
  localparam logic [CONST_BITS-1:0] C20 = 15'd9102;
  localparam logic [CONST_BITS-1:0] C24 = 15'd6270;
  localparam logic [CONST_BITS-1:0] C28 = 15'd3196;

  // multiplier operand sources
  localparam logic [3:0] SRC_A0PA1 = 4'd0;
  localparam logic [3:0] SRC_A0MA1 = 4'd1;
  localparam logic [3:0] SRC_A2 = 4'd2;
  localparam logic [3:0] SRC_A3 = 4'd3;
  localparam logic [3:0] SRC_S6MS5 = 4'd4;
  localparam logic [3:0] SRC_S6PS5 = 4'd5;
  localparam logic [3:0] SRC_B0 = 4'd6;
  localparam logic [3:0] SRC_B1 = 4'd7;
  localparam logic [3:0] SRC_B2 = 4'd8;
  localparam logic [3:0] SRC_B3 = 4'd9;

  // result destinations: 0..7 are outputs o0..o7
  localparam logic [3:0] DST_R5 = 4'd8;
  localparam logic [3:0] DST_R6 = 4'd9;

  localparam int NUM_STEPS = 16;

  typedef struct packed {
    logic [3:0] src;
    logic [CONST_BITS-1:0] cst;
    logic neg;
    logic first;
    logic last;
    logic [3:0] dst;
  } fdct_op_t;

  typedef struct packed {
    logic load;
    logic [2:0] load_idx;
    logic issue;
    logic [3:0] step;
  } fdct_ctl_t;

  // operand width inside the butterfly
  function automatic int fdct_val_w(int sb);
    return ((sb + 2 > PASS_BITS) ? sb + 2 : PASS_BITS) + 4;
  endfunction

  function automatic fdct_op_t fdct_decode(logic [3:0] step);
    fdct_op_t op;
    op = '0;
    case (step)
      4'd0: op = '{SRC_A0PA1, C16, 1'b0, 1'b1, 1'b1, 4'd0};
      4'd1: op = '{SRC_A0MA1, C16, 1'b0, 1'b1, 1'b1, 4'd4};
      4'd2: op = '{SRC_A2, C24, 1'b0, 1'b1, 1'b0, 4'd0};
      4'd3: op = '{SRC_A3, C8, 1'b0, 1'b0, 1'b1, 4'd2};
      4'd4: op = '{SRC_A3, C24, 1'b0, 1'b1, 1'b0, 4'd0};
      4'd5: op = '{SRC_A2, C8, 1'b1, 1'b0, 1'b1, 4'd6};
      4'd6: op = '{SRC_S6MS5, C16, 1'b0, 1'b1, 1'b1, DST_R5};
      4'd7: op = '{SRC_S6PS5, C16, 1'b0, 1'b1, 1'b1, DST_R6};
      4'd8: op = '{SRC_B0, C28, 1'b0, 1'b1, 1'b0, 4'd0};
      4'd9: op = '{SRC_B3, C4, 1'b0, 1'b0, 1'b1, 4'd1};
      4'd10: op = '{SRC_B1, C12, 1'b0, 1'b1, 1'b0, 4'd0};
      4'd11: op = '{SRC_B2, C20, 1'b0, 1'b0, 1'b1, 4'd5};
      4'd12: op = '{SRC_B2, C12, 1'b0, 1'b1, 1'b0, 4'd0};
      4'd13: op = '{SRC_B1, C20, 1'b1, 1'b0, 1'b1, 4'd3};
      4'd14: op = '{SRC_B3, C28, 1'b0, 1'b1, 1'b0, 4'd0};
      4'd15: op = '{SRC_B0, C4, 1'b1, 1'b0, 1'b1, 4'd7};
      default: op = '0;
    endcase
    return op;
  endfunction

endpackage

@@ src/fdct_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module fdct_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/fdct_unit.sv @@
// 8-point butterfly built around one shared multiplier and accumulator.
`timescale 1ns / 1ps
module fdct_unit
  import fdct_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  fdct_ctl_t                               ctl,
  input  logic [fdct_val_w(SAMPLE_BITS)-1:0]      vin,
  output logic [7:0][fdct_val_w(SAMPLE_BITS)+2:0] coefs
);

  localparam int VW = fdct_val_w(SAMPLE_BITS);
  localparam int PW = VW + CONST_BITS;
  localparam int SW = PW + 2;
  localparam int RW = SW - ROUND_SHIFT;

  logic signed [VW-1:0] v [8];
  logic signed [VW-1:0] s0, s1, s2, s3, s4, s5, s6, s7;
  logic signed [VW-1:0] a0, a1, a2, a3;
  logic signed [VW-1:0] r5, r6, b0, b1, b2, b3;
  logic signed [VW-1:0] opnd;
  fdct_op_t op;

  logic p1_valid;
  fdct_op_t p1_op;
  logic signed [PW-1:0] prod;
  logic signed [SW-1:0] acc, base, sum;
  logic signed [RW-1:0] rnd;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      v[ctl.load_idx] <= $signed(vin);
    end
  end

  always_comb begin
    s0 = v[0] + v[7];
    s1 = v[1] + v[6];
    s2 = v[2] + v[5];
    s3 = v[3] + v[4];
    s4 = v[3] - v[4];
    s5 = v[2] - v[5];
    s6 = v[1] - v[6];
    s7 = v[0] - v[7];
    a0 = s0 + s3;
    a1 = s1 + s2;
    a2 = s1 - s2;
    a3 = s0 - s3;
    b0 = s4 + r5;
    b1 = s4 - r5;
    b2 = s7 - r6;
    b3 = s7 + r6;
  end

  always_comb begin
    op = fdct_decode(ctl.step);
    case (op.src)
      SRC_A0PA1: opnd = a0 + a1;
      SRC_A0MA1: opnd = a0 - a1;
      SRC_A2:    opnd = a2;
      SRC_A3:    opnd = a3;
      SRC_S6MS5: opnd = s6 - s5;
      SRC_S6PS5: opnd = s6 + s5;
      SRC_B0:    opnd = b0;
      SRC_B1:    opnd = b1;
      SRC_B2:    opnd = b2;
      SRC_B3:    opnd = b3;
      default:   opnd = '0;
    endcase
  end

  // stage 0: multiply
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= ctl.issue;
    end
    p1_op <= op;
    prod <= opnd * $signed(op.cst);
  end

  // stage 1: accumulate with rounding bias folded into the first term
  always_comb begin
    base = p1_op.first ? SW'(ROUND_BIAS) : acc;
    sum = p1_op.neg ? base - SW'(prod) : base + SW'(prod);
    rnd = sum[SW-1:ROUND_SHIFT];
  end

  always_ff @(posedge clk) begin
    if (p1_valid) begin
      acc <= sum;
      if (p1_op.last) begin
        if (p1_op.dst == DST_R5) begin
          r5 <= rnd[VW-1:0];
        end else if (p1_op.dst == DST_R6) begin
          r6 <= rnd[VW-1:0];
        end else begin
          coefs[p1_op.dst[2:0]] <= rnd;
        end
      end
    end
  end

endmodule

@@ src/forward_dct_8x8.sv @@
// Top level of the 8x8 forward DCT: sample capture, sequencer and result output.
// Loading takes one sample per cycle while start is high; busy rises after the 64th sample.
// Each of the 16 one-dimensional transforms reads eight values, runs the 16 multiplies
// on the shared multiplier and writes eight results; busy stays high until the last one ends.
// Coefficients come only from the second pass, in bursts of eight, one per cycle, one
// burst per transform; results cannot be stalled.
// Reset is synchronous and empties the sample count and sequencer; stores keep no reset value.
`timescale 1ns / 1ps
module forward_dct_8x8
  import fdct_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [SAMPLE_BITS-1:0] residual,
  output logic                          busy,
  output logic                          valid,
  output logic signed [COEF_BITS-1:0]   coefficient,
  output logic [5:0]                    position,
  output logic                          final_flag
);

  localparam int VW = fdct_val_w(SAMPLE_BITS);
  localparam int RW = VW + 3;

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_RD = 2'd1;
  localparam logic [1:0] ST_CALC = 2'd2;
  localparam logic [1:0] ST_WB = 2'd3;
  localparam logic [4:0] CALC_END = 5'd17;

  logic [1:0] state;
  logic [5:0] load_count;
  logic pass;
  logic [2:0] line;
  logic [4:0] cnt;
  logic ld_valid;
  logic [2:0] ld_idx;

  logic [SAMPLE_BITS-1:0] samp_rd;
  logic [PASS_BITS-1:0] pass_rd;
  logic [VW-1:0] vin;
  logic [7:0][RW-1:0] coefs;
  fdct_ctl_t ctl;

  logic accept;
  logic [5:0] col_addr;
  logic signed [RW-1:0] ow, half;

  assign accept = start && !busy;
  assign busy = (state != ST_LOAD);
  assign col_addr = {cnt[2:0], line};

  fdct_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(64)) u_sample_store (
    .clk(clk),
    .we(accept),
    .waddr(load_count),
    .wdata(residual),
    .raddr(col_addr),
    .rdata(samp_rd)
  );

  fdct_ram #(.WIDTH(PASS_BITS), .DEPTH(64)) u_pass_store (
    .clk(clk),
    .we(state == ST_WB && !pass),
    .waddr({line, cnt[2:0]}),
    .wdata(ow[PASS_BITS-1:0]),
    .raddr(col_addr),
    .rdata(pass_rd)
  );

  // first pass scales samples by 4
  always_comb begin
    if (pass) begin
      vin = {{(VW-PASS_BITS){pass_rd[PASS_BITS-1]}}, pass_rd};
    end else begin
      vin = {{(VW-SAMPLE_BITS-2){samp_rd[SAMPLE_BITS-1]}}, samp_rd, 2'b00};
    end
  end

  always_comb begin
    ctl.load = ld_valid;
    ctl.load_idx = ld_idx;
    ctl.issue = (state == ST_CALC) && (cnt != '0) && (cnt <= 5'(NUM_STEPS));
    ctl.step = 4'(cnt - 5'd1);
  end

  fdct_unit #(.SAMPLE_BITS(SAMPLE_BITS)) u_unit (
    .clk(clk),
    .rst(rst),
    .ctl(ctl),
    .vin(vin),
    .coefs(coefs)
  );

  // halve with truncation toward zero
  always_comb begin
    ow = $signed(coefs[cnt[2:0]]);
    half = (ow + {{(RW-1){1'b0}}, ow[RW-1]}) >>> 1;
  end

  always_ff @(posedge clk) begin
    ld_idx <= cnt[2:0];
    coefficient <= half[COEF_BITS-1:0];
    position <= {line, cnt[2:0]};
    if (rst) begin
      state <= ST_LOAD;
      load_count <= '0;
      pass <= 1'b0;
      line <= '0;
      cnt <= '0;
      ld_valid <= 1'b0;
      valid <= 1'b0;
      final_flag <= 1'b0;
    end else begin
      ld_valid <= (state == ST_RD);
      valid <= (state == ST_WB) && pass;
      final_flag <= (state == ST_WB) && pass && (line == 3'd7) && (cnt[2:0] == 3'd7);
      case (state)
        ST_LOAD: begin
          if (accept) begin
            load_count <= load_count + 6'd1;
            if (load_count == 6'd63) begin
              state <= ST_RD;
              pass <= 1'b0;
              line <= '0;
              cnt <= '0;
            end
          end
        end
        ST_RD: begin
          if (cnt[2:0] == 3'd7) begin
            state <= ST_CALC;
            cnt <= '0;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        ST_CALC: begin
          if (cnt == CALC_END) begin
            state <= ST_WB;
            cnt <= '0;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        ST_WB: begin
          if (cnt[2:0] == 3'd7) begin
            cnt <= '0;
            line <= line + 3'd1;
            if (line == 3'd7) begin
              if (pass) begin
                state <= ST_LOAD;
              end else begin
                pass <= 1'b1;
                state <= ST_RD;
              end
            end else begin
              state <= ST_RD;
            end
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

endmodule

@@ src/fdct_checker.sv @@
// Port-level checker for the 8x8 forward DCT, bound to the top level.
`timescale 1ns / 1ps
module fdct_checker
  import fdct_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 busy,
  input logic                 valid,
  input logic [COEF_BITS-1:0] coefficient,
  input logic [5:0]           position,
  input logic                 final_flag
);

  // the last beat leaves the output register after busy has dropped
  a_valid_busy: assert property (@(posedge clk) disable iff (rst)
    valid |-> !$isunknown(coefficient) && (busy || final_flag))
    else $error("result beat while idle");

  a_final_pos: assert property (@(posedge clk) disable iff (rst)
    final_flag |-> valid && position == 6'd63)
    else $error("final flag off the last coefficient");

  a_burst: assert property (@(posedge clk) disable iff (rst)
    valid && position[2:0] != 3'd7 |=> valid && position == $past(position) + 6'd1)
    else $error("row burst broken");

  a_idle_after: assert property (@(posedge clk) disable iff (rst)
    valid && final_flag |=> !busy && !valid)
    else $error("block did not end after last coefficient");

  a_reset: assert property (@(posedge clk) rst |=> !busy && !valid)
    else $error("reset did not idle the block");

endmodule

bind forward_dct_8x8 fdct_checker u_fdct_checker (
  .clk(clk),
  .rst(rst),
  .busy(busy),
  .valid(valid),
  .coefficient(coefficient),
  .position(position),
  .final_flag(final_flag)
);
